[hdl/tce_pkg.sv]
`default_nettype none

package tce_pkg;

  // Field widths of the input and result words.
  localparam int CMD_W    = 2;
  localparam int CON_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  // Control characters.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SCROLL = 2'd1,
    OP_MOVE   = 2'd2,
    OP_READ   = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t            op_kind;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [CHAR_W-1:0]   letter;
    logic                last;
  } res_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } seq_state_t;

endpackage

`default_nettype wire

[hdl/tce_in_if.sv]
`default_nettype none

interface tce_in_if;
  import tce_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CON_W-1:0]  console;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, cmd, console, char_code, read_row, read_col,
                  input ready);
  modport sink (input valid, cmd, console, char_code, read_row, read_col,
                output ready);
endinterface

`default_nettype wire

[hdl/tce_out_if.sv]
`default_nettype none

interface tce_out_if;
  import tce_pkg::*;

  logic              valid;
  logic              ready;
  op_kind_t          op_kind;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [CHAR_W-1:0] letter;
  logic              last;

  modport source (output valid, op_kind, row, col, letter, last, input ready);
  modport sink (input valid, op_kind, row, col, letter, last, output ready);
endinterface

`default_nettype wire

[hdl/tce_ram.sv]
`default_nettype none

module tce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem_r[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hdl/tce_obuf.sv]
`default_nettype none

module tce_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tce_pkg::res_t push_res,
  output logic          can_push,
  tce_out_if.source     out_ch
);
  import tce_pkg::*;

  logic valid_r;
  res_t res_r;

  // The slot takes a new word when empty or when its word leaves this cycle.
  assign can_push = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= push_res;
    end
  end

  assign out_ch.valid   = valid_r;
  assign out_ch.op_kind = res_r.op_kind;
  assign out_ch.row     = res_r.row;
  assign out_ch.col     = res_r.col;
  assign out_ch.letter  = res_r.letter;
  assign out_ch.last    = res_r.last;

endmodule

`default_nettype wire

[hdl/tce_seq.sv]
`default_nettype none

module tce_seq #(
  parameter int CONSOLES = 4,
  parameter int ROWS     = 25,
  parameter int COLS     = 80,
  parameter int NW       = 2,
  parameter int RW       = 5,
  parameter int CW       = 7,
  parameter int AW       = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tce_in_if.sink                     in_ch,
  input  logic                       cfg_wr_en,
  input  logic [tce_pkg::CON_W-1:0]  cfg_wr_data,
  input  logic                       can_push,
  output logic                       push,
  output tce_pkg::res_t              push_res,
  output logic                       mem_we,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_addr,
  output logic [tce_pkg::CHAR_W-1:0] mem_wr_data,
  input  logic [tce_pkg::CHAR_W-1:0] mem_rd_data
);
  import tce_pkg::*;

  // Screen row to physical row through the ring top pointer.
  function automatic logic [RW-1:0] phys(input logic [RW-1:0] top,
                                         input logic [RW-1:0] r);
    logic [RW:0] s;
    s = {1'b0, top} + {1'b0, r};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  seq_state_t state_r, state_nxt;
  logic [CON_W-1:0] cur_con_r;

  // Per-console context.
  logic [CW-1:0] col_r [CONSOLES];
  logic [RW-1:0] row_r [CONSOLES];
  logic [CW-1:0] lim_r [CONSOLES];
  logic [RW-1:0] top_r [CONSOLES];

  logic [AW-1:0] init_cnt_r, init_cnt_nxt;

  logic pend_wr_r, pend_wr_nxt;
  logic pend_scr_r, pend_scr_nxt;
  logic pend_mv_r, pend_mv_nxt;
  logic [ROW_W-1:0]  wr_row_r, wr_row_nxt;
  logic [COL_W-1:0]  wr_col_r, wr_col_nxt;
  logic [CHAR_W-1:0] wr_let_r, wr_let_nxt;
  logic [ROW_W-1:0]  mv_row_r, mv_row_nxt;
  logic [COL_W-1:0]  mv_col_r, mv_col_nxt;
  logic [ROW_W-1:0]  rd_row_r, rd_row_nxt;
  logic [COL_W-1:0]  rd_col_r, rd_col_nxt;
  logic              rd_ok_r, rd_ok_nxt;

  logic          clr_act_r, clr_act_nxt;
  logic [NW-1:0] clr_con_r, clr_con_nxt;
  logic [RW-1:0] clr_row_r, clr_row_nxt;
  logic [CW-1:0] clr_col_r, clr_col_nxt;

  logic          con_ok;
  logic [NW-1:0] idx;
  logic [CW-1:0] cc, lm;
  logic [RW-1:0] cr, tp;
  logic          show;
  logic          line;
  logic          ctx_we;
  logic [CW-1:0] col_n, lim_n;
  logic [RW-1:0] row_n, top_n;
  logic [CHAR_W-1:0] put_ch;

  assign con_ok = 32'(in_ch.console) < CONSOLES;
  assign idx    = NW'(in_ch.console);
  assign cc     = col_r[idx];
  assign cr     = row_r[idx];
  assign lm     = lim_r[idx];
  assign tp     = top_r[idx];
  assign show   = in_ch.console == cur_con_r;
  assign put_ch = (in_ch.char_code == CH_TAB) ? CH_SPACE : in_ch.char_code;

  always_comb begin
    state_nxt    = state_r;
    init_cnt_nxt = init_cnt_r;
    pend_wr_nxt  = pend_wr_r;
    pend_scr_nxt = pend_scr_r;
    pend_mv_nxt  = pend_mv_r;
    wr_row_nxt   = wr_row_r;
    wr_col_nxt   = wr_col_r;
    wr_let_nxt   = wr_let_r;
    mv_row_nxt   = mv_row_r;
    mv_col_nxt   = mv_col_r;
    rd_row_nxt   = rd_row_r;
    rd_col_nxt   = rd_col_r;
    rd_ok_nxt    = rd_ok_r;
    clr_act_nxt  = clr_act_r;
    clr_con_nxt  = clr_con_r;
    clr_row_nxt  = clr_row_r;
    clr_col_nxt  = clr_col_r;
    in_ch.ready  = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = '0;
    mem_wr_data  = '0;
    push         = 1'b0;
    push_res     = '0;
    ctx_we       = 1'b0;
    line         = 1'b0;
    col_n        = cc;
    lim_n        = lm;
    row_n        = cr;
    top_n        = tp;

    unique case (state_r)
      ST_INIT: begin
        mem_we       = 1'b1;
        mem_addr     = init_cnt_r;
        init_cnt_nxt = init_cnt_r + 1'b1;
        if (init_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && con_ok) begin
          unique case (in_ch.cmd)
            CMD_END: begin
              ctx_we = 1'b1;
              lim_n  = cc;
            end
            CMD_READ: begin
              mem_re     = 1'b1;
              mem_addr   = {idx, phys(tp, RW'(in_ch.read_row)), CW'(in_ch.read_col)};
              rd_ok_nxt  = (32'(in_ch.read_row) < ROWS) && (32'(in_ch.read_col) < COLS);
              rd_row_nxt = in_ch.read_row;
              rd_col_nxt = in_ch.read_col;
              state_nxt  = ST_READ;
            end
            CMD_PUT: begin
              ctx_we = 1'b1;
              if (in_ch.char_code == CH_NEWLINE) begin
                col_n = '0;
                lim_n = '0;
                line  = 1'b1;
              end else if (in_ch.char_code == CH_BACKSPACE) begin
                if (cc > lm) begin
                  col_n       = cc - 1'b1;
                  mem_we      = 1'b1;
                  mem_addr    = {idx, phys(tp, cr), CW'(cc - 1'b1)};
                  pend_wr_nxt = show;
                  wr_row_nxt  = ROW_W'(cr);
                  wr_col_nxt  = COL_W'(CW'(cc - 1'b1));
                  wr_let_nxt  = '0;
                end
              end else begin
                mem_we      = 1'b1;
                mem_addr    = {idx, phys(tp, cr), cc};
                mem_wr_data = put_ch;
                pend_wr_nxt = show;
                wr_row_nxt  = ROW_W'(cr);
                wr_col_nxt  = COL_W'(cc);
                wr_let_nxt  = put_ch;
                if (cc == CW'(COLS - 1)) begin
                  col_n = '0;
                  lim_n = '0;
                  line  = 1'b1;
                end else begin
                  col_n = cc + 1'b1;
                end
              end
              if (line) begin
                if (cr >= RW'(ROWS - 1)) begin
                  clr_act_nxt  = 1'b1;
                  clr_con_nxt  = idx;
                  clr_row_nxt  = tp;
                  clr_col_nxt  = '0;
                  top_n        = (tp == RW'(ROWS - 1)) ? '0 : tp + 1'b1;
                  pend_scr_nxt = show;
                end else begin
                  row_n = cr + 1'b1;
                end
              end
              pend_mv_nxt = show;
              mv_row_nxt  = ROW_W'(row_n);
              mv_col_nxt  = COL_W'(col_n);
              state_nxt   = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        if (can_push) begin
          push             = 1'b1;
          push_res.op_kind = OP_READ;
          push_res.row     = rd_row_r;
          push_res.col     = rd_col_r;
          push_res.letter  = rd_ok_r ? mem_rd_data : '0;
          push_res.last    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end

      ST_EMIT: begin
        // The row sweep owns the memory port; words go out alongside it.
        if (clr_act_r) begin
          mem_we   = 1'b1;
          mem_addr = {clr_con_r, clr_row_r, clr_col_r};
          if (clr_col_r == CW'(COLS - 1)) begin
            clr_act_nxt = 1'b0;
          end else begin
            clr_col_nxt = clr_col_r + 1'b1;
          end
        end
        if (can_push) begin
          priority if (pend_wr_r) begin
            push             = 1'b1;
            push_res.op_kind = OP_WRITE;
            push_res.row     = wr_row_r;
            push_res.col     = wr_col_r;
            push_res.letter  = wr_let_r;
            pend_wr_nxt      = 1'b0;
          end else if (pend_scr_r) begin
            push             = 1'b1;
            push_res.op_kind = OP_SCROLL;
            pend_scr_nxt     = 1'b0;
          end else if (pend_mv_r) begin
            push             = 1'b1;
            push_res.op_kind = OP_MOVE;
            push_res.row     = mv_row_r;
            push_res.col     = mv_col_r;
            push_res.last    = 1'b1;
            pend_mv_nxt      = 1'b0;
          end
        end
        if (!pend_wr_nxt && !pend_scr_nxt && !pend_mv_nxt && !clr_act_nxt) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      cur_con_r  <= '0;
      init_cnt_r <= '0;
      pend_wr_r  <= 1'b0;
      pend_scr_r <= 1'b0;
      pend_mv_r  <= 1'b0;
      clr_act_r  <= 1'b0;
      for (int i = 0; i < CONSOLES; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
        lim_r[i] <= '0;
        top_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      init_cnt_r <= init_cnt_nxt;
      pend_wr_r  <= pend_wr_nxt;
      pend_scr_r <= pend_scr_nxt;
      pend_mv_r  <= pend_mv_nxt;
      clr_act_r  <= clr_act_nxt;
      if (cfg_wr_en) begin
        cur_con_r <= cfg_wr_data;
      end
      if (ctx_we) begin
        col_r[idx] <= col_n;
        row_r[idx] <= row_n;
        lim_r[idx] <= lim_n;
        top_r[idx] <= top_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_row_r  <= wr_row_nxt;
    wr_col_r  <= wr_col_nxt;
    wr_let_r  <= wr_let_nxt;
    mv_row_r  <= mv_row_nxt;
    mv_col_r  <= mv_col_nxt;
    rd_row_r  <= rd_row_nxt;
    rd_col_r  <= rd_col_nxt;
    rd_ok_r   <= rd_ok_nxt;
    clr_con_r <= clr_con_nxt;
    clr_row_r <= clr_row_nxt;
    clr_col_r <= clr_col_nxt;
  end

endmodule

`default_nettype wire

[hdl/text_console_char_engine_unit.sv]
// A read or shown put passes the sequencer's read or emit state and the output register
// before its first result word. End of write and ignored commands go back to back; a read
// or put holds the input while its results drain, one per cycle while the output slot
// takes them, and a scroll holds it until the old top row is cleared. Reset (synchronous,
// rst_n low) clears cursors, limits, top pointers and the console select, then sweeps the
// cell memory's whole address range to zero, one address per cycle, before taking input.
`default_nettype none

module text_console_char_engine_unit #(
  parameter int CONSOLES = 4,
  parameter int ROWS     = 25,
  parameter int COLS     = 80
) (
  input  logic                      clk,
  input  logic                      rst_n,
  tce_in_if.sink                    in_ch,
  tce_out_if.source                 out_ch,
  input  logic                      cfg_wr_en,
  input  logic [tce_pkg::CON_W-1:0] cfg_wr_data
);
  import tce_pkg::*;

  // The cell memory is addressed as {console, physical row, column}, each
  // field padded to a power of two so no multiplier sits in the address path.
  localparam int NW = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int AW = NW + RW + CW;

  logic              push;
  res_t              push_res;
  logic              can_push;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_addr;
  logic [CHAR_W-1:0] mem_wr_data;
  logic [CHAR_W-1:0] mem_rd_data;

  // The sequencer holds the per-console cursor context in flip-flops and
  // issues every access to the cell memory. A put that changes a cell writes it in
  // the cycle the word is accepted; the result words then drain one per cycle, as the
  // output slot takes them, while a scroll sweeps the old top row to zero.
  tce_seq #(
    .CONSOLES (CONSOLES),
    .ROWS     (ROWS),
    .COLS     (COLS),
    .NW       (NW),
    .RW       (RW),
    .CW       (CW),
    .AW       (AW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .can_push    (can_push),
    .push        (push),
    .push_res    (push_res),
    .mem_we      (mem_we),
    .mem_re      (mem_re),
    .mem_addr    (mem_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  // Character store for all consoles, single port with a registered read.
  tce_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (2**AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .re      (mem_re),
    .addr    (mem_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  // Output register: decouples the result channel from the sequencer.
  tce_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (push_res),
    .can_push (can_push),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // The memory has one port, so a read and a write never share a cycle.
  a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re)
    else $error("cell memory read and write in the same cycle");

  // A result is only handed over when the output slot can take it.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("result word pushed into a full output slot");

  // A scroll word carries no position and no letter.
  a_scroll_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_res.op_kind == OP_SCROLL) |->
      (push_res.row == '0 && push_res.col == '0 && push_res.letter == '0))
    else $error("scroll word with nonzero fields");

  // A read of a valid console waits for the memory before taking more input.
  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.cmd == CMD_READ &&
     32'(in_ch.console) < CONSOLES) |=> !in_ch.ready)
    else $error("input taken while a read is outstanding");
`endif

endmodule

`default_nettype wire

[sim/tb_text_console_char_engine_unit.sv]
`timescale 1ns / 1ps

module tb_text_console_char_engine_unit;
  import tce_pkg::*;

  // Geometry of the block as instantiated (its defaults).
  localparam int NUM_CON  = 4;
  localparam int NUM_ROWS = 25;
  localparam int NUM_COLS = 80;

  // The one command code the package leaves unnamed; the block must ignore it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Run limit in clock cycles. It covers the memory sweep after reset, a few hundred
  // words that each scroll and emit three results into a receiver that stalls, the long
  // receiver hold and the idle waits, many times over.
  localparam int CYCLE_LIMIT = 400000;

  // Cycles allowed for a silent word (for example a scroll on a console that is
  // not shown) to finish its row clearing before the console select is changed.
  localparam int SETTLE_CYCLES = 150;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CON_W-1:0] cfg_wr_data;

  tce_in_if  in_ch();
  tce_out_if out_ch();

  text_console_char_engine_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Shadow copy of every console: the cell store in physical row order, the
  // cursor, the backspace limit and the ring pointer to the top screen row.
  logic [CHAR_W-1:0] cells [NUM_CON][NUM_ROWS][NUM_COLS];
  int cur_col   [NUM_CON];
  int cur_row   [NUM_CON];
  int limit_col [NUM_CON];
  int top_row   [NUM_CON];
  logic [CON_W-1:0] shown_con;

  // Display operations the block still owes, oldest first.
  res_t pending_display_ops[$];

  int  fault_count;
  int  result_index;
  bit  no_gaps;       // both sides run without idling when set
  int  hold_cycles;   // long receiver hold, counted down by the receiver process
  int  rx_wait;       // per-result receiver stall

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow model of the consoles.
  // ---------------------------------------------------------------------------

  task automatic push_op(input op_kind_t kind, input int r, input int c,
                         input logic [CHAR_W-1:0] letter, input bit last);
    res_t op;
    op.op_kind = kind;
    op.row     = r[ROW_W-1:0];
    op.col     = c[COL_W-1:0];
    op.letter  = letter;
    op.last    = last;
    pending_display_ops.push_back(op);
  endtask

  // Moves the cursor of a console down one row. On the last row the screen
  // scrolls instead: the ring pointer advances and the old top row, which
  // becomes the new bottom row, is blanked. Returns 1 when it scrolled.
  function automatic bit advance_line(input int con);
    int p;
    if (cur_row[con] >= NUM_ROWS - 1) begin
      p = top_row[con];
      for (int j = 0; j < NUM_COLS; j++) cells[con][p][j] = '0;
      top_row[con] = (p + 1) % NUM_ROWS;
      return 1'b1;
    end
    cur_row[con]++;
    return 1'b0;
  endfunction

  // Applies one accepted word to the shadow state and queues the display
  // operations it must cause.
  task automatic model_word(input logic [CMD_W-1:0] cmd, input logic [CON_W-1:0] con,
                            input logic [CHAR_W-1:0] ch, input logic [ROW_W-1:0] rr,
                            input logic [COL_W-1:0] rc);
    bit mirror;
    bit rolled;
    int prow;
    logic [CHAR_W-1:0] glyph;
    mirror = (con == shown_con);
    rolled = 1'b0;
    glyph  = ch;
    if (cmd == CMD_END) begin
      limit_col[con] = cur_col[con];
    end else if (cmd == CMD_READ) begin
      // Reads answer on every console; cells off the screen read as blank.
      glyph = '0;
      if (rr < NUM_ROWS && rc < NUM_COLS) begin
        prow  = (top_row[con] + rr) % NUM_ROWS;
        glyph = cells[con][prow][rc];
      end
      push_op(OP_READ, rr, rc, glyph, 1'b1);
    end else if (cmd == CMD_PUT) begin
      if (ch == CH_NEWLINE) begin
        cur_col[con]   = 0;
        limit_col[con] = 0;
        rolled = advance_line(con);
      end else if (ch == CH_BACKSPACE) begin
        // Backspace never eats into text that an earlier end of write protected.
        if (cur_col[con] > limit_col[con]) begin
          cur_col[con]--;
          prow = (top_row[con] + cur_row[con]) % NUM_ROWS;
          cells[con][prow][cur_col[con]] = '0;
          if (mirror) push_op(OP_WRITE, cur_row[con], cur_col[con], '0, 1'b0);
        end
      end else begin
        if (ch == CH_TAB) glyph = CH_SPACE;
        prow = (top_row[con] + cur_row[con]) % NUM_ROWS;
        cells[con][prow][cur_col[con]] = glyph;
        if (mirror) push_op(OP_WRITE, cur_row[con], cur_col[con], glyph, 1'b0);
        cur_col[con]++;
        if (cur_col[con] >= NUM_COLS) begin
          cur_col[con]   = 0;
          limit_col[con] = 0;
          rolled = advance_line(con);
        end
      end
      // A shown console always ends a put with a cursor move.
      if (mirror) begin
        if (rolled) push_op(OP_SCROLL, 0, 0, '0, 1'b0);
        push_op(OP_MOVE, cur_row[con], cur_col[con], '0, 1'b1);
      end
    end
    // The unused command code leaves everything untouched.
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge, check an accepted result against the oldest
  // expectation, then feed an accepted input word to the shadow model. The
  // check comes first so that a stray result is never matched against an
  // expectation queued at the same edge.
  // ---------------------------------------------------------------------------

  task automatic log_fault(input string what, input res_t want, input res_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("result %0d %s: expected kind %0d row %0d col %0d letter %0d last %0d,"
               , result_index, what, want.op_kind, want.row, want.col, want.letter,
               want.last,
               " got kind %0d row %0d col %0d letter %0d last %0d",
               got.op_kind, got.row, got.col, got.letter, got.last);
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.op_kind = out_ch.op_kind;
        got.row     = out_ch.row;
        got.col     = out_ch.col;
        got.letter  = out_ch.letter;
        got.last    = out_ch.last;
        if (pending_display_ops.size() == 0) begin
          log_fault("arrived with nothing expected", '0, got);
        end else begin
          want = pending_display_ops.pop_front();
          if (got.op_kind !== want.op_kind || got.row !== want.row ||
              got.col !== want.col || got.letter !== want.letter ||
              got.last !== want.last)
            log_fault("mismatch", want, got);
        end
        result_index++;
        rx_wait = no_gaps ? 0 : $urandom_range(0, 5);
      end
      if (in_ch.valid && in_ch.ready)
        model_word(in_ch.cmd, in_ch.console, in_ch.char_code, in_ch.read_row,
                   in_ch.read_col);
    end
  end

  // Receiver: ready changes at the falling edge. A long hold takes precedence
  // over the short per-result stall.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles--;
      end else if (rx_wait > 0) begin
        out_ch.ready = 1'b0;
        rx_wait--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Watchdog: a hung block ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("text_console_char_engine_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one word after a random gap and returns at the edge that takes it.
  // Valid stays high on return so that a following word can go back to back;
  // whoever stops sending must lower it (see wait_results_done).
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CON_W-1:0] con,
                           input logic [CHAR_W-1:0] ch, input logic [ROW_W-1:0] rr,
                           input logic [COL_W-1:0] rc);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    repeat (gap) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.cmd       = cmd;
    in_ch.console   = con;
    in_ch.char_code = ch;
    in_ch.read_row  = rr;
    in_ch.read_col  = rc;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Unused fields carry random noise so that the block is seen to ignore them.
  task automatic put_char(input logic [CON_W-1:0] con, input logic [CHAR_W-1:0] ch);
    send_word(CMD_PUT, con, ch, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic end_write(input logic [CON_W-1:0] con);
    send_word(CMD_END, con, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic read_cell(input logic [CON_W-1:0] con, input logic [ROW_W-1:0] r,
                           input logic [COL_W-1:0] c);
    send_word(CMD_READ, con, CHAR_W'($urandom), r, c);
  endtask

  // Any byte that is printed as itself.
  function automatic logic [CHAR_W-1:0] plain_byte();
    logic [CHAR_W-1:0] b;
    do b = CHAR_W'($urandom_range(0, 255));
    while (b == CH_NEWLINE || b == CH_BACKSPACE || b == CH_TAB);
    return b;
  endfunction

  task automatic wait_results_done();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_display_ops.size() != 0) @(posedge clk);
  endtask

  // Changes the shown console only once the block has gone quiet. Silent words
  // leave nothing to wait for, so a fixed settle time follows the last result.
  task automatic select_console(input logic [CON_W-1:0] con);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = con;
    shown_con   = con;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Short directed walk over the edges of the fields and every command with the
  // reset selection (console 0 shown).
  task automatic test_basic_commands();
    read_cell(0, 0, 0);                    // store is blank after the sweep
    put_char(0, 8'd65);
    put_char(0, 8'h00);                    // lowest byte is stored as is
    put_char(0, 8'hFF);
    put_char(0, CH_TAB);                   // tab prints a space
    end_write(0);                          // limit now at column 4
    put_char(0, CH_BACKSPACE);             // at the limit: cursor move only
    put_char(0, 8'd66);
    put_char(0, CH_BACKSPACE);             // beyond the limit: clears the cell
    read_cell(0, 0, 4);
    read_cell(0, 0, 2);
    read_cell(0, 5'd31, 7'd127);           // both coordinates off the screen
    read_cell(0, ROW_W'(NUM_ROWS - 1), COL_W'(NUM_COLS));  // column just past the edge
    read_cell(0, ROW_W'(NUM_ROWS), COL_W'(NUM_COLS - 1));  // row just past the edge
    send_word(CMD_UNUSED, 2'd3, 8'hFF, 5'h1F, 7'h7F);
    put_char(0, CH_NEWLINE);
    put_char(0, CH_BACKSPACE);             // column 0: nothing to erase
    put_char(1, 8'd120);                   // hidden console: silent update
    read_cell(1, 0, 0);
    end_write(2);
    put_char(2, CH_NEWLINE);
    put_char(0, 8'd127);
    put_char(0, 8'd128);
    read_cell(0, 0, 3);
  endtask

  // One line longer than the screen width forces a wrap; then newlines with
  // short random text run the cursor to the bottom and scroll twice.
  task automatic test_wrap_and_scroll(input logic [CON_W-1:0] con);
    repeat (NUM_COLS + 5) put_char(con, plain_byte());
    repeat (NUM_ROWS) begin
      put_char(con, CH_NEWLINE);
      repeat ($urandom_range(0, 2)) put_char(con, plain_byte());
    end
    read_cell(con, 0, COL_W'($urandom_range(0, 4)));
    read_cell(con, ROW_W'(NUM_ROWS - 2), 0);
    read_cell(con, ROW_W'(NUM_ROWS - 1), 0);
    read_cell(con, ROW_W'(NUM_ROWS - 1), COL_W'(NUM_COLS - 1));
  endtask

  // The receiver holds off for a long stretch while words keep coming without
  // gaps, so the result path backs up and the input must stall.
  task automatic test_result_backpressure(input logic [CON_W-1:0] con);
    no_gaps     = 1'b1;
    hold_cycles = 300;
    repeat (40) begin
      if ($urandom_range(0, 9) == 0) put_char(con, CH_NEWLINE);
      else put_char(con, plain_byte());
    end
    no_gaps = 1'b0;
    wait_results_done();
  endtask

  // Random words, mostly to the shown console. Now and then the sender stops
  // until every owed result has come back.
  task automatic test_random_traffic(input int words);
    int pick;
    logic [CON_W-1:0] con;
    for (int i = 0; i < words; i++) begin
      pick = $urandom_range(0, 99);
      con  = ($urandom_range(0, 9) < 6) ? shown_con : CON_W'($urandom_range(0, 3));
      if (pick < 55) put_char(con, plain_byte());
      else if (pick < 68) put_char(con, CH_NEWLINE);
      else if (pick < 78) put_char(con, CH_BACKSPACE);
      else if (pick < 81) put_char(con, CH_TAB);
      else if (pick < 86) end_write(con);
      else if (pick < 97) begin
        if ($urandom_range(0, 4) == 0)
          read_cell(con, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
        else
          read_cell(con, ROW_W'($urandom_range(0, NUM_ROWS - 1)),
                    COL_W'($urandom_range(0, NUM_COLS - 1)));
      end else begin
        send_word(CMD_UNUSED, con, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
      end
      if ($urandom_range(0, 39) == 0) wait_results_done();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------

  initial begin
    foreach (cells[a, b, c]) cells[a][b][c] = '0;
    foreach (cur_col[k]) begin
      cur_col[k]   = 0;
      cur_row[k]   = 0;
      limit_col[k] = 0;
      top_row[k]   = 0;
    end
    shown_con       = '0;
    fault_count     = 0;
    result_index    = 0;
    no_gaps         = 1'b0;
    hold_cycles     = 0;
    rx_wait         = 0;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_PUT;
    in_ch.console   = '0;
    in_ch.char_code = '0;
    in_ch.read_row  = '0;
    in_ch.read_col  = '0;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // The block sweeps its store after reset; the first word simply waits.
    test_basic_commands();

    select_console(2'd3);
    test_wrap_and_scroll(2'd3);
    test_result_backpressure(2'd3);

    select_console(2'd1);
    test_random_traffic(40);

    // A stretch with no idling on either side.
    select_console(2'd2);
    no_gaps = 1'b1;
    test_random_traffic(30);
    no_gaps = 1'b0;

    select_console(2'd0);
    test_random_traffic(30);

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("text_console_char_engine_unit test passed");
    end else begin
      $display("text_console_char_engine_unit test failed");
    end
    $finish;
  end

endmodule
